// ===== src/m4vt_pkg.sv =====
// shared types and constants for the 4x4 q16.16 transform engine
package m4vt_pkg;

  // default matrix dimension
  localparam int M4VT_DIM_DEF = 4;
  // vector components and result rows carried on the ports
  localparam int M4VT_LANES = 4;
  // q16.16 word and intermediate widths
  localparam int M4VT_W = 32;
  localparam int M4VT_PROD_W = 2 * M4VT_W;
  localparam int M4VT_PAIR_W = M4VT_PROD_W + 1;
  localparam int M4VT_SUM_W = M4VT_PROD_W + 2;
  localparam int M4VT_FRAC = 16;
  localparam int M4VT_RND_W = M4VT_SUM_W - M4VT_FRAC;
  // port widths
  localparam int M4VT_IN_DATA_W = 168;
  localparam int M4VT_OUT_DATA_W = M4VT_LANES * M4VT_W;

  // kind codes carried in s_axis_tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  // half an lsb of the result, for round-half-up
  localparam logic signed [M4VT_SUM_W-1:0] M4VT_HALF = M4VT_SUM_W'(1) <<< (M4VT_FRAC - 1);
  localparam logic signed [M4VT_W-1:0] M4VT_MAX = {1'b0, {(M4VT_W-1){1'b1}}};
  localparam logic signed [M4VT_W-1:0] M4VT_MIN = {1'b1, {(M4VT_W-1){1'b0}}};

  typedef logic signed [M4VT_W-1:0] word_t;

  // load enables of the arithmetic stages
  typedef struct packed {
    logic mul;
    logic pair;
    logic total;
    logic outp;
  } stage_en_t;

endpackage

// ===== src/m4vt_dot.sv =====
// one result row: four products, adder tree, rounding and saturation
module m4vt_dot
  import m4vt_pkg::*;
(
  input  logic      clk,
  input  stage_en_t en,
  input  word_t     coef [M4VT_LANES],
  input  word_t     vec  [M4VT_LANES],
  output word_t     res,
  output logic      sat
);

  logic signed [M4VT_PROD_W-1:0] prod [M4VT_LANES];
  logic signed [M4VT_PAIR_W-1:0] pair [2];
  logic signed [M4VT_RND_W-1:0]  rnd;
  logic signed [M4VT_SUM_W-1:0]  total;
  logic                          rnd_sat;
  word_t                         res_next;

  // exact products, one multiplier per lane
  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int c = 0; c < M4VT_LANES; c++) begin
        prod[c] <= M4VT_PROD_W'(coef[c]) * M4VT_PROD_W'(vec[c]);
      end
    end
  end

  // first level of the adder tree
  always_ff @(posedge clk) begin
    if (en.pair) begin
      pair[0] <= M4VT_PAIR_W'(prod[0]) + M4VT_PAIR_W'(prod[1]);
      pair[1] <= M4VT_PAIR_W'(prod[2]) + M4VT_PAIR_W'(prod[3]);
    end
  end

  // full sum plus half lsb, then drop the fraction
  assign total = M4VT_SUM_W'(pair[0]) + M4VT_SUM_W'(pair[1]) + M4VT_HALF;

  always_ff @(posedge clk) begin
    if (en.total) begin
      rnd <= total[M4VT_SUM_W-1:M4VT_FRAC];
    end
  end

  // saturate to 32 bits when the upper bits are not a sign extension
  assign rnd_sat = !((&rnd[M4VT_RND_W-1:M4VT_W-1]) || !(|rnd[M4VT_RND_W-1:M4VT_W-1]));

  always_comb begin
    if (rnd_sat) begin
      res_next = rnd[M4VT_RND_W-1] ? M4VT_MIN : M4VT_MAX;
    end else begin
      res_next = rnd[M4VT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.outp) begin
      res <= res_next;
      sat <= rnd_sat;
    end
  end

endmodule

// ===== src/mat4_vector_transform.sv =====
// top level of the 4x4 q16.16 matrix-vector transform engine
//
//  channel   direction  tdata                              tuser
//  s_axis    in         index, value, x, y, z, w (168 b)   kind
//  m_axis    out        out_x, out_y, out_z, out_w (128 b) overflow
//
// one transaction per cycle in steady state while m_axis_tready is high; a
// transform result passes the input register, multiply, pair add, round and
// saturate registers in order. loads write the matrix at the multiply stage, so
// order against transforms is kept; they produce no output transaction.
// rst clears the valid bits and the matrix to zero. a stall on m_axis holds
// every full stage, and bubbles are squeezed out ahead of it.
module mat4_vector_transform
  import m4vt_pkg::*;
#(
  parameter int DIM = M4VT_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // element_index[3:0], element_value[35:4], vec_x[67:36], vec_y[99:68],
  // vec_z[131:100], vec_w[163:132], zero pad[167:164]
  input  logic [M4VT_IN_DATA_W-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [M4VT_OUT_DATA_W-1:0] m_axis_tdata,
  // overflow[0]
  output logic                       m_axis_tuser
);

  // columns and rows that reach the ports
  localparam int NC = (DIM < M4VT_LANES) ? DIM : M4VT_LANES;
  localparam int NR = NC;

  // input register
  logic       v1;
  logic       kind1;
  logic [3:0] idx1;
  word_t      value1;
  word_t      vec1 [M4VT_LANES];

  // valid bits of the arithmetic stages, v5 is the output register
  logic v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  stage_en_t en;

  word_t matrix [NC][NR];
  word_t res [M4VT_LANES];
  logic [M4VT_LANES-1:0] sat;

  // stall chain: a stage loads when it is empty or its content moves on
  assign en5 = !v5 || m_axis_tready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  assign en.mul = en2;
  assign en.pair = en3;
  assign en.total = en4;
  assign en.outp = en5;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1 <= s_axis_tuser;
      idx1 <= s_axis_tdata[3:0];
      value1 <= s_axis_tdata[35:4];
      for (int c = 0; c < M4VT_LANES; c++) begin
        vec1[c] <= s_axis_tdata[36 + c*M4VT_W +: M4VT_W];
      end
    end
  end

  // valid bits; loads leave the pipe at the multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en2) v2 <= v1 && (kind1 == KIND_XFORM);
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // matrix store, written by a load as it passes the multiply stage
  for (genvar c = 0; c < NC; c++) begin : g_col
    for (genvar r = 0; r < NR; r++) begin : g_row
      always_ff @(posedge clk) begin
        if (rst) begin
          matrix[c][r] <= '0;
        end else if (en2 && v1 && (kind1 == KIND_LOAD) &&
                     ({4'b0, idx1} == 8'(c*DIM + r))) begin
          matrix[c][r] <= value1;
        end
      end
    end
  end

  // one dot-product row per result component
  for (genvar r = 0; r < M4VT_LANES; r++) begin : g_dot
    if (r < NR) begin : g_used
      word_t coef [M4VT_LANES];
      for (genvar c = 0; c < M4VT_LANES; c++) begin : g_coef
        if (c < NC) begin : g_real
          assign coef[c] = matrix[c][r];
        end else begin : g_zero
          assign coef[c] = '0;
        end
      end

      m4vt_dot u_dot (
        .clk  (clk),
        .en   (en),
        .coef (coef),
        .vec  (vec1),
        .res  (res[r]),
        .sat  (sat[r])
      );
    end else begin : g_unused
      assign res[r] = '0;
      assign sat[r] = 1'b0;
    end
  end

  // output transaction
  assign m_axis_tvalid = v5;
  assign m_axis_tuser = |sat;
  for (genvar r = 0; r < M4VT_LANES; r++) begin : g_out
    assign m_axis_tdata[r*M4VT_W +: M4VT_W] = res[r];
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the 4x4 q16.16 matrix-vector transform engine
`timescale 1ns / 1ps

module tb
  import m4vt_pkg::*;
();

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_AT_ITEM = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  // one transform result: four rows plus the saturation flag
  typedef struct packed {
    logic                ovf;
    logic [3:0][31:0]    row;
  } xform_result_t;

  // keeps a copy of the matrix and predicts every transform result
  class xform_scoreboard;
    word_t         matrix [16];
    xform_result_t expected_results [$];
    int            failures;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      failures = 0;
    endfunction

    // matrix times vector, exact sum, round half up, saturate
    function xform_result_t multiply_rounded(word_t vec [4]);
      xform_result_t                   res;
      logic signed [M4VT_PROD_W-1:0]   prod;
      logic signed [M4VT_SUM_W-1:0]    acc;
      res = '0;
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int c = 0; c < 4; c++) begin
          prod = matrix[c * 4 + r] * vec[c];
          acc += prod;
        end
        acc = (acc + M4VT_HALF) >>> M4VT_FRAC;
        if (acc > M4VT_MAX) begin
          res.row[r] = M4VT_MAX;
          res.ovf = 1'b1;
        end else if (acc < M4VT_MIN) begin
          res.row[r] = M4VT_MIN;
          res.ovf = 1'b1;
        end else begin
          res.row[r] = acc[31:0];
        end
      end
      return res;
    endfunction

    // accepted input transaction: update the matrix or queue a prediction
    function void note_input(logic kind, logic [M4VT_IN_DATA_W-1:0] d);
      word_t vec [4];
      if (kind == KIND_LOAD) begin
        matrix[d[3:0]] = d[35:4];
      end else begin
        for (int i = 0; i < 4; i++) vec[i] = d[36 + 32 * i +: 32];
        expected_results.push_back(multiply_rounded(vec));
      end
    endfunction

    // accepted output transaction: compare with the oldest prediction
    function void check_result(logic [M4VT_OUT_DATA_W-1:0] d, logic ovf);
      string         lane_name [4] = '{"out_x", "out_y", "out_z", "out_w"};
      xform_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction, tdata %h", d);
        failures++;
        return;
      end
      exp_res = expected_results.pop_front();
      for (int r = 0; r < 4; r++) begin
        if (d[32 * r +: 32] !== exp_res.row[r]) begin
          $error("%s mismatch: expected %0d, actual %0d", lane_name[r],
                 $signed(exp_res.row[r]), $signed(d[32 * r +: 32]));
          failures++;
        end
      end
      if (ovf !== exp_res.ovf) begin
        $error("overflow mismatch: expected %0d, actual %0d", exp_res.ovf, ovf);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [M4VT_IN_DATA_W-1:0]  s_axis_tdata;
  logic                       s_axis_tuser;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [M4VT_OUT_DATA_W-1:0] m_axis_tdata;
  logic                       m_axis_tuser;

  xform_scoreboard sb = new();
  int              items_sent = 0;
  int              send_idle_pct = 0;
  int              cycles = 0;

  mat4_vector_transform uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle stretch length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // q16.16 value: small fractions, whole numbers, full range or corner values
  function automatic word_t rand_q16();
    int    sel;
    word_t corner [7];
    corner = '{M4VT_MAX, M4VT_MIN, 32'sd0, 32'sd1, -32'sd1, 32'sh10000, 32'sh8000};
    sel = $urandom_range(9);
    if (sel < 4) return int'($urandom_range(524288)) - 262144;
    if (sel < 6) return int'($urandom_range(33554432)) - 16777216;
    if (sel < 8) return $urandom;
    if (sel == 8) return corner[$urandom_range(6)];
    return (int'($urandom_range(64)) - 32) <<< 16;
  endfunction

  // offer one transaction and wait until it is taken
  task automatic send_item(input logic kind, input logic [3:0] idx, input word_t val,
                           input word_t x, input word_t y, input word_t z, input word_t w);
    int                        gap;
    logic [M4VT_IN_DATA_W-1:0] d;
    d = {4'b0, w, z, y, x, val, idx};
    gap = ($urandom_range(99) < send_idle_pct) ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(kind, d);
    items_sent++;
    if (items_sent % 100 == 0) send_idle_pct = ($urandom_range(2) == 0) ? 0 :
                                               ($urandom_range(1) ? 15 : 50);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [3:0] idx, input word_t val);
    send_item(KIND_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_xform(input word_t x, input word_t y, input word_t z, input word_t w);
    send_item(KIND_XFORM, 4'($urandom), $urandom, x, y, z, w);
  endtask

  // receiver: random stalls plus one long hold-off to back up the pipeline
  initial begin
    int stall_left;
    int hold_left;
    int rate;
    int cyc;
    bit held;
    stall_left = 0;
    hold_left = 0;
    rate = 0;
    cyc = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 150 == 0) rate = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 10 : 35);
      if (!held && items_sent >= HOLD_AT_ITEM) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(99) < rate) begin
        stall_left = idle_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    int    order [16];
    int    j;
    int    tmp;
    int    target;
    word_t big;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_LOAD;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero matrix after reset, extreme vectors, ignored load fields set
    send_item(KIND_XFORM, 4'hF, M4VT_MIN, M4VT_MAX, M4VT_MAX, M4VT_MAX, M4VT_MAX);
    send_item(KIND_XFORM, 4'h0, M4VT_MAX, M4VT_MIN, M4VT_MIN, M4VT_MIN, M4VT_MIN);
    // diagonal with extremes; vector fields of loads are ignored
    send_item(KIND_LOAD, 4'd0, M4VT_MAX, '1, '1, '1, '1);
    send_load(4'd5, M4VT_MIN);
    send_load(4'd10, 32'sh10000);
    send_load(4'd15, 32'sd1);
    // saturation high, low, and from a product of two minimums
    send_xform(M4VT_MAX, 0, 0, 0);
    send_xform(M4VT_MIN, 0, 0, 0);
    send_xform(0, M4VT_MIN, 0, 0);
    send_xform(0, M4VT_MAX, 0, 0);
    // rounding: exactly half up, minus half, just below minus half
    send_xform(0, 0, 0, 32'sh8000);
    send_xform(0, 0, 0, -32'sh8000);
    send_xform(0, 0, 0, -32'sh8001);
    send_xform(0, 0, 32'sh12345678, 32'sh7FFF);
    // two large products in one row
    send_load(4'd12, M4VT_MAX);
    send_xform(M4VT_MAX, 0, 0, M4VT_MAX);
    send_xform(M4VT_MAX, 0, 0, M4VT_MIN);
    send_load(4'd12, M4VT_MIN);
    send_xform(M4VT_MIN, M4VT_MIN, M4VT_MIN, M4VT_MIN);
    send_xform(32'sh10000, -32'sh10000, 32'sh8000, -32'sd3);

    // random part: full matrix loads followed by vector bursts, stray loads, and vector bursts alone
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(9) < 3) begin
        for (int i = 0; i < 16; i++) order[i] = i;
        for (int i = 15; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < 16; i++) send_load(4'(order[i]), rand_q16());
        repeat ($urandom_range(4, 40)) send_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
      end else if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) send_load(4'($urandom), rand_q16());
      end else begin
        repeat ($urandom_range(1, 12)) begin
          big = rand_q16();
          send_xform(big, rand_q16(), rand_q16(), rand_q16());
        end
      end
    end

    // drain
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/m4vt_pkg.sv
src/m4vt_dot.sv
src/mat4_vector_transform.sv
tb/sv/tb.sv
